// ===== sv/cvt_pkg.sv =====
package cvt_pkg;

    localparam int TRIG_FRAC_BITS = 15;
    localparam int QUARTER        = 1440;
    localparam int HALF_TURN      = 2880;
    localparam int THREE_QUARTER  = 4320;
    localparam int FULL_TURN      = 5760;

    localparam int POS_W   = 32;
    localparam int ANG_W   = 14;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int DIFF_W  = POS_W + 1;
    localparam int COORD_W = 40;
    localparam int TAB_W   = TRIG_FRAC_BITS + 1;
    localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
    localparam int PROD_W  = COORD_W + TRIG_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int IDX_W   = $clog2(QUARTER + 1);
    localparam int MOD_W   = 15;
    localparam int STEP_W  = 3;
    localparam int NUM_STEPS = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
    localparam int PIPE_DEPTH = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_Z = 3'd5;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (TRIG_FRAC_BITS - 1);

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] TAYLOR_DIV [1:10] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
          64'd156, 64'd210, 64'd272, 64'd342, 64'd420};
    localparam int ROUND_SH = 30 - TRIG_FRAC_BITS;

    typedef logic [TAB_W-1:0] t_sine_tab [QUARTER+1];
    typedef logic signed [TRIG_W-1:0] t_trig_val;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0] t_diff_val;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_cam_pos;

    typedef struct packed {
        t_trig_val sin_x;
        t_trig_val cos_x;
        t_trig_val sin_y;
        t_trig_val cos_y;
        t_trig_val sin_z;
        t_trig_val cos_z;
    } t_trig;

    typedef struct packed {
        t_diff_val dx;
        t_diff_val dy;
        t_diff_val dz;
    } t_diff;

    // Quarter-wave sine, Q30 Taylor series rounded to the table precision.
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        logic signed [63:0] one;
        one = 64'sd1 <<< TRIG_FRAC_BITS;
        for (int k = 0; k <= QUARTER; k++) begin
            x    = (64'(k) * PI_Q30 + 64'd1440) / 64'd2880;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 10; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = sum;
            if (ROUND_SH > 0) begin
                v = (sum + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
            end
            if (v > one) begin
                v = one;
            end
            tab[k] = v[TAB_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

// ===== sv/cvt_trig.sv =====
module cvt_trig (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cvt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cvt_pkg::CFG_W-1:0]     i_cfg_data,
    output cvt_pkg::t_cam_pos             o_cam,
    output cvt_pkg::t_trig                o_trig,
    output logic                          o_busy
);
    import cvt_pkg::*;

    logic signed [POS_W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic signed [ANG_W-1:0] r_ang_x, r_ang_y, r_ang_z;
    logic                    r_issue;
    logic [STEP_W-1:0]       r_step;
    logic                    r_wr_v;
    logic [STEP_W-1:0]       r_wr_step;
    logic [TAB_W-1:0]        r_rom_q;
    logic                    r_rom_neg;
    t_trig_val               r_val [NUM_STEPS];

    logic signed [ANG_W-1:0] ang;
    logic signed [MOD_W-1:0] m;
    logic signed [MOD_W-1:0] mc;
    logic signed [MOD_W-1:0] mm;
    logic [IDX_W-1:0]        n_idx;
    logic                    n_neg;
    logic                    ang_wr;

    assign ang_wr = i_cfg_we &&
        (i_cfg_idx == CFG_ANG_X || i_cfg_idx == CFG_ANG_Y || i_cfg_idx == CFG_ANG_Z);

    // Reduce the negated angle to one turn, then fold it onto the quarter table.
    always_comb begin
        case (r_step[2:1])
            2'd0:    ang = r_ang_x;
            2'd1:    ang = r_ang_y;
            2'd2:    ang = r_ang_z;
            default: ang = r_ang_x;
        endcase
        m = -MOD_W'(ang);
        if (m < 0) m = m + MOD_W'(FULL_TURN);
        if (m < 0) m = m + MOD_W'(FULL_TURN);
        if (m >= MOD_W'(FULL_TURN)) m = m - MOD_W'(FULL_TURN);
        mc = m + MOD_W'(QUARTER);
        if (mc >= MOD_W'(FULL_TURN)) mc = mc - MOD_W'(FULL_TURN);
        mm = r_step[0] ? mc : m;
        n_neg = (mm >= MOD_W'(HALF_TURN));
        if (mm < MOD_W'(QUARTER)) begin
            n_idx = IDX_W'(mm);
        end else if (mm < MOD_W'(HALF_TURN)) begin
            n_idx = IDX_W'(MOD_W'(HALF_TURN) - mm);
        end else if (mm < MOD_W'(THREE_QUARTER)) begin
            n_idx = IDX_W'(mm - MOD_W'(HALF_TURN));
        end else begin
            n_idx = IDX_W'(MOD_W'(FULL_TURN) - mm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
            r_ang_x <= '0;
            r_ang_y <= '0;
            r_ang_z <= '0;
            r_issue <= 1'b1;
            r_step  <= '0;
            r_wr_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POS_X: r_pos_x <= i_cfg_data[POS_W-1:0];
                    CFG_POS_Y: r_pos_y <= i_cfg_data[POS_W-1:0];
                    CFG_POS_Z: r_pos_z <= i_cfg_data[POS_W-1:0];
                    CFG_ANG_X: r_ang_x <= i_cfg_data[ANG_W-1:0];
                    CFG_ANG_Y: r_ang_y <= i_cfg_data[ANG_W-1:0];
                    CFG_ANG_Z: r_ang_z <= i_cfg_data[ANG_W-1:0];
                    default:   ;
                endcase
            end
            if (ang_wr) begin
                r_issue <= 1'b1;
                r_step  <= '0;
            end else if (r_issue) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(NUM_STEPS - 1)) r_issue <= 1'b0;
            end
            r_wr_v <= r_issue && !ang_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rom_q   <= SINE_TAB[n_idx];
        r_rom_neg <= n_neg;
        r_wr_step <= r_step;
        if (r_wr_v) begin
            r_val[r_wr_step] <= r_rom_neg ? -TRIG_W'(r_rom_q) : TRIG_W'(r_rom_q);
        end
    end

    assign o_cam.x = r_pos_x;
    assign o_cam.y = r_pos_y;
    assign o_cam.z = r_pos_z;
    assign o_trig.sin_x = r_val[0];
    assign o_trig.cos_x = r_val[1];
    assign o_trig.sin_y = r_val[2];
    assign o_trig.cos_y = r_val[3];
    assign o_trig.sin_z = r_val[4];
    assign o_trig.cos_z = r_val[5];
    assign o_busy = r_issue || r_wr_v;

endmodule

// ===== sv/cvt_front.sv =====
module cvt_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [31:0]              i_vert_x,
    input  logic [31:0]              i_vert_y,
    input  logic [31:0]              i_vert_z,
    input  cvt_pkg::t_cam_pos        i_cam,
    input  logic                     i_busy,
    input  logic                     i_pop,
    output cvt_pkg::t_diff           o_head,
    output logic                     o_nonempty
);
    import cvt_pkg::*;

    t_diff                   r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count;
    logic                    push;
    t_diff                   n_diff;

    assign o_in_ready = (r_count != FIFO_CNT_W'(FIFO_DEPTH)) && !i_busy;
    assign push       = i_in_valid && o_in_ready;
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    always_comb begin
        n_diff.dx = DIFF_W'($signed(i_vert_x)) - DIFF_W'(i_cam.x);
        n_diff.dy = DIFF_W'($signed(i_vert_y)) - DIFF_W'(i_cam.y);
        n_diff.dz = DIFF_W'($signed(i_vert_z)) - DIFF_W'(i_cam.z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= n_diff;
    end

endmodule

// ===== sv/cvt_rot.sv =====
module cvt_rot (
    input  logic               i_clk,
    input  logic               i_en,
    input  cvt_pkg::t_trig_val i_sin,
    input  cvt_pkg::t_trig_val i_cos,
    input  cvt_pkg::t_coord    i_p,
    input  cvt_pkg::t_coord    i_q,
    output cvt_pkg::t_coord    o_p,
    output cvt_pkg::t_coord    o_q
);
    import cvt_pkg::*;

    logic signed [PROD_W-1:0] r_cp, r_sq, r_sp, r_cq;
    logic signed [SUM_W-1:0]  n_sum_p, n_sum_q;
    t_coord                   r_p, r_q;

    // Round half up, then drop the fraction bits.
    assign n_sum_p = SUM_W'(r_cp) - SUM_W'(r_sq) + ROUND_HALF;
    assign n_sum_q = SUM_W'(r_sp) + SUM_W'(r_cq) + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cp <= i_cos * i_p;
            r_sq <= i_sin * i_q;
            r_sp <= i_sin * i_p;
            r_cq <= i_cos * i_q;
            r_p  <= n_sum_p[TRIG_FRAC_BITS +: COORD_W];
            r_q  <= n_sum_q[TRIG_FRAC_BITS +: COORD_W];
        end
    end

    assign o_p = r_p;
    assign o_q = r_q;

endmodule

// ===== sv/cvt_back.sv =====
module cvt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cvt_pkg::t_diff i_head,
    input  logic           i_nonempty,
    output logic           o_pop,
    input  cvt_pkg::t_trig i_trig,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [31:0]    o_view_x,
    output logic [31:0]    o_view_y,
    output logic [31:0]    o_view_z,
    output logic           o_saturated
);
    import cvt_pkg::*;

    logic                  adv;
    logic [PIPE_DEPTH-1:0] r_v;
    logic                  r_out_v;
    t_coord                dx, dy, dz;
    t_coord                x1, y1, x2, z2, y3, z3;
    t_coord                r_dz_d1, r_dz_d2, r_y1_d1, r_y1_d2, r_x2_d1, r_x2_d2;
    logic [31:0]           r_vx, r_vy, r_vz;
    logic                  r_sat;
    logic                  ov_x, un_x, ov_y, un_y, ov_z, un_z;

    assign adv   = !r_out_v || i_out_ready;
    assign o_pop = adv && i_nonempty;

    assign dx = {{(COORD_W-DIFF_W){i_head.dx[DIFF_W-1]}}, i_head.dx};
    assign dy = {{(COORD_W-DIFF_W){i_head.dy[DIFF_W-1]}}, i_head.dy};
    assign dz = {{(COORD_W-DIFF_W){i_head.dz[DIFF_W-1]}}, i_head.dz};

    cvt_rot u_rot_z (
        .i_clk (i_clk), .i_en (adv), .i_sin (i_trig.sin_z), .i_cos (i_trig.cos_z),
        .i_p (dx), .i_q (dy), .o_p (x1), .o_q (y1)
    );

    cvt_rot u_rot_y (
        .i_clk (i_clk), .i_en (adv), .i_sin (i_trig.sin_y), .i_cos (i_trig.cos_y),
        .i_p (x1), .i_q (r_dz_d2), .o_p (x2), .o_q (z2)
    );

    cvt_rot u_rot_x (
        .i_clk (i_clk), .i_en (adv), .i_sin (i_trig.sin_x), .i_cos (i_trig.cos_x),
        .i_p (r_y1_d2), .i_q (z2), .o_p (y3), .o_q (z3)
    );

    always_comb begin
        ov_x = !r_x2_d2[COORD_W-1] && (|r_x2_d2[COORD_W-2:31]);
        un_x =  r_x2_d2[COORD_W-1] && !(&r_x2_d2[COORD_W-2:31]);
        ov_y = !y3[COORD_W-1] && (|y3[COORD_W-2:31]);
        un_y =  y3[COORD_W-1] && !(&y3[COORD_W-2:31]);
        ov_z = !z3[COORD_W-1] && (|z3[COORD_W-2:31]);
        un_z =  z3[COORD_W-1] && !(&z3[COORD_W-2:31]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_v     <= {r_v[PIPE_DEPTH-2:0], o_pop};
            r_out_v <= r_v[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dz_d1 <= dz;
            r_dz_d2 <= r_dz_d1;
            r_y1_d1 <= y1;
            r_y1_d2 <= r_y1_d1;
            r_x2_d1 <= x2;
            r_x2_d2 <= r_x2_d1;
            r_vx  <= ov_x ? 32'h7FFF_FFFF : (un_x ? 32'h8000_0000 : r_x2_d2[31:0]);
            r_vy  <= ov_y ? 32'h7FFF_FFFF : (un_y ? 32'h8000_0000 : y3[31:0]);
            r_vz  <= ov_z ? 32'h7FFF_FFFF : (un_z ? 32'h8000_0000 : z3[31:0]);
            r_sat <= ov_x || un_x || ov_y || un_y || ov_z || un_z;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_view_x    = r_vx;
    assign o_view_y    = r_vy;
    assign o_view_z    = r_vz;
    assign o_saturated = r_sat;

endmodule

// ===== sv/camera_view_transform_zyx_core.sv =====
// Channel  | Handshake                  | Payload
// ---------+----------------------------+--------------------------------------
// input    | i_in_valid / o_in_ready    | i_vert_x, i_vert_y, i_vert_z
// output   | o_out_valid / i_out_ready  | o_view_x, o_view_y, o_view_z, o_saturated
// config   | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// One vertex transfer per cycle sustained while the sequencer is idle and the output
// is not stalled; stages: queue write, three rotations of multiply + round, clamp.
// The rotation pipeline with its three multiplier banks sets the rate.
// Reset is synchronous, active low; afterwards, and after every angle write, the
// sine/cosine sequencer runs with o_in_ready low.
// A stalled output freezes the back pipeline; the 4-entry queue keeps the input
// side taking transfers until it fills.
module camera_view_transform_zyx_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [31:0]                   i_vert_x,
    input  logic [31:0]                   i_vert_y,
    input  logic [31:0]                   i_vert_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [31:0]                   o_view_x,
    output logic [31:0]                   o_view_y,
    output logic [31:0]                   o_view_z,
    output logic                          o_saturated,
    input  logic                          i_cfg_we,
    input  logic [cvt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cvt_pkg::CFG_W-1:0]     i_cfg_data
);
    import cvt_pkg::*;

    t_cam_pos cam;
    t_trig    trig;
    t_diff    head;
    logic     busy;
    logic     pop;
    logic     nonempty;

    // Configuration registers and the trig sequencer (quarter-wave ROM).
    cvt_trig u_trig (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cam      (cam),
        .o_trig     (trig),
        .o_busy     (busy)
    );

    // Front: subtract the camera position and queue the difference.
    cvt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_vert_x   (i_vert_x),
        .i_vert_y   (i_vert_y),
        .i_vert_z   (i_vert_z),
        .i_cam      (cam),
        .i_busy     (busy),
        .i_pop      (pop),
        .o_head     (head),
        .o_nonempty (nonempty)
    );

    // Back: rotate about z, y, x, then clamp into the output register.
    cvt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_nonempty  (nonempty),
        .o_pop       (pop),
        .i_trig      (trig),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_view_x    (o_view_x),
        .o_view_y    (o_view_y),
        .o_view_z    (o_view_z),
        .o_saturated (o_saturated)
    );

endmodule

// ===== sv/cvt_checker.sv =====
module cvt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [31:0]                   i_vert_x,
    input logic [31:0]                   i_vert_y,
    input logic [31:0]                   i_vert_z,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [31:0]                   o_view_x,
    input logic [31:0]                   o_view_y,
    input logic [31:0]                   o_view_z,
    input logic                          o_saturated,
    input logic                          i_cfg_we,
    input logic [cvt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [cvt_pkg::CFG_W-1:0]     i_cfg_data
);
    import cvt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_view_x) && $stable(o_view_y) && $stable(o_view_z) &&
            $stable(o_saturated))
        else $error("output payload changed while stalled");

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready while trig table loads after reset");

    a_angle_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx == CFG_ANG_X || i_cfg_idx == CFG_ANG_Y ||
                     i_cfg_idx == CFG_ANG_Z) |=> !o_in_ready)
        else $error("input ready right after an angle write");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            o_view_x == 32'h7FFF_FFFF || o_view_x == 32'h8000_0000 ||
            o_view_y == 32'h7FFF_FFFF || o_view_y == 32'h8000_0000 ||
            o_view_z == 32'h7FFF_FFFF || o_view_z == 32'h8000_0000)
        else $error("saturation flag without a clamped coordinate");

endmodule

bind camera_view_transform_zyx_core cvt_checker u_cvt_checker (.*);
